/* rtl/hop_channel_frequency_defines.svh */
// ============================================================================
// Assertion macros for the hop channel frequency block
// Concurrent property wrappers, compiled out when NO_ASSERTIONS is defined.
// ============================================================================
`ifndef HOP_CHANNEL_FREQUENCY_DEFINES_SVH
`define HOP_CHANNEL_FREQUENCY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset
`define HCF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hop_channel_frequency: assertion failed");

// Next-cycle implication, disabled during reset
`define HCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hop_channel_frequency: assertion failed");

`else

`define HCF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/hcf_pkg.sv */
// ============================================================================
// Hop channel frequency package
// Widths, slot constants and per-slot sub-band tables.
// ============================================================================
`timescale 1ns / 1ps

package hcf_pkg;

    // Field widths
    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int KEY_W   = 31;
    localparam int SUM_W   = 32;
    localparam int PSUM_W  = 13;
    localparam int HZ_W    = 24;
    localparam int SLOT_W  = 4;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 32;

    // Remainder pipeline: one bit of the sum per step
    localparam int MOD_STAGES   = 8;
    localparam int MOD_BITS     = SUM_W / MOD_STAGES;

    // Clamp limits
    localparam logic [SEC_W-1:0]  SEC_MAX  = SEC_W'(59);
    localparam logic [MIN_W-1:0]  MIN_MAX  = MIN_W'(59);
    localparam logic [HOUR_W-1:0] HOUR_MAX = HOUR_W'(23);

    // Slot number range at the output
    localparam logic [SLOT_W-1:0] SLOT_NUM_MIN = SLOT_W'(1);
    localparam logic [SLOT_W-1:0] SLOT_NUM_MAX = SLOT_W'(10);

    // Frequency range in kHz
    localparam int KHZ_MIN = 1622;
    localparam int KHZ_MAX = 11585;

    typedef logic [SLOT_W-1:0] t_slot;   // 0..9 inside the pipe
    typedef logic [10:0]       t_width;  // slot total width, up to 1314
    typedef logic [13:0]       t_khz;    // frequency in kHz, up to 11584

    // Thresholds and start adjustments for the sub-band walk:
    // off < t1 -> a0 + off; off < t2 -> a1 + off; else a2 + off
    typedef struct packed {
        t_width t1;
        t_width t2;
        t_khz   a0;
        t_khz   a1;
        t_khz   a2;
    } t_band;

    // Total band width of a slot
    function automatic t_width slot_width(input t_slot slot);
        t_width w;
        unique case (slot)
            4'd0:    w = 11'd352;
            4'd1:    w = 11'd460;
            4'd2:    w = 11'd263;
            4'd3:    w = 11'd260;
            4'd4:    w = 11'd643;
            4'd5:    w = 11'd715;
            4'd6:    w = 11'd534;
            4'd7:    w = 11'd844;
            4'd8:    w = 11'd1314;
            4'd9:    w = 11'd1280;
            default: w = 11'd352;
        endcase
        return w;
    endfunction

    // Sub-band layout of a slot; unused bands repeat the last one
    function automatic t_band slot_band(input t_slot slot);
        t_band b;
        unique case (slot)
            4'd0:    b = '{t1: 11'd352, t2: 11'd352,  a0: 14'd1622, a1: 14'd1622, a2: 14'd1622};
            4'd1:    b = '{t1: 11'd183, t2: 11'd460,  a0: 14'd1975, a1: 14'd2023, a2: 14'd2023};
            4'd2:    b = '{t1: 11'd93,  t2: 11'd263,  a0: 14'd2517, a1: 14'd2572, a2: 14'd2572};
            4'd3:    b = '{t1: 11'd215, t2: 11'd260,  a0: 14'd3170, a1: 14'd3300, a2: 14'd3300};
            4'd4:    b = '{t1: 11'd324, t2: 11'd643,  a0: 14'd3561, a1: 14'd3691, a2: 14'd3691};
            4'd5:    b = '{t1: 11'd300, t2: 11'd515,  a0: 14'd4335, a1: 14'd4465, a2: 14'd4560};
            4'd6:    b = '{t1: 11'd189, t2: 11'd329,  a0: 14'd5276, a1: 14'd5556, a2: 14'd5886};
            4'd7:    b = '{t1: 11'd89,  t2: 11'd494,  a0: 14'd6421, a1: 14'd6691, a2: 14'd6971};
            4'd8:    b = '{t1: 11'd984, t2: 11'd1314, a0: 14'd7816, a1: 14'd8071, a2: 14'd8071};
            4'd9:    b = '{t1: 11'd65,  t2: 11'd1110, a0: 14'd9915, a1: 14'd10050, a2: 14'd10305};
            default: b = '{t1: 11'd352, t2: 11'd352,  a0: 14'd1622, a1: 14'd1622, a2: 14'd1622};
        endcase
        return b;
    endfunction

endpackage

/* rtl/hop_channel_frequency.sv */
// ============================================================================
// Hop channel frequency
// Maps a wall-clock time and the network key to a hopping channel frequency.
// ============================================================================
//  channel   | direction | tdata / data fields (lsb first)
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | second[5:0] minute[11:6] hour[16:12] day[21:17]
//  m_axis    | out       | frequency_hz[23:0] slot_index[27:24]
//  cfg       | in        | network_key[30:0], always ready
//
//  One item enters per cycle unless m_axis stalls; each result passes through
//  the 32-step remainder chain, spread over 8 stages of 4 steps, plus input,
//  key-add, band-walk and scale stages before it leaves.
//  A stall on m_axis freezes the whole pipe; s_axis ready follows it.
//  Reset is synchronous, active low, and clears the valid bits and the key.
// ============================================================================
`timescale 1ns / 1ps

module hop_channel_frequency (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // second, minute, hour, day (lsb first), zero padded
    input  logic [hcf_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // frequency_hz, slot_index (lsb first), zero padded
    output logic [hcf_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic [hcf_pkg::KEY_W-1:0]          i_cfg_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready
);

    import hcf_pkg::*;

    `include "hop_channel_frequency_defines.svh"

    // One remainder step block: shift in MOD_BITS bits, restoring subtract each
    function automatic t_width mod_step(input t_width rem, input logic [MOD_BITS-1:0] bits,
                                        input t_width div);
        logic [11:0] acc;
        t_width      r;
        r = rem;
        for (int b = MOD_BITS - 1; b >= 0; b--) begin
            acc = {r, bits[b]};
            if (acc >= {1'b0, div}) begin
                acc = acc - {1'b0, div};
            end
            r = acc[10:0];
        end
        return r;
    endfunction

    logic w_adv;

    // Configuration register
    logic [KEY_W-1:0] r_network_key;

    // Stage 1: partial sum of the clamped time, slot
    logic               r_s1_vld;
    logic [PSUM_W-1:0]  r_s1_psum;
    t_slot              r_s1_slot;

    // Stage 2: full sum and divisor
    logic               r_s2_vld;
    logic [SUM_W-1:0]   r_s2_sum;
    t_slot              r_s2_slot;
    t_width             r_s2_div;

    // Remainder stages
    logic               r_m_vld  [MOD_STAGES];
    logic [SUM_W-1:0]   r_m_sum  [MOD_STAGES];
    t_width             r_m_rem  [MOD_STAGES];
    t_width             r_m_div  [MOD_STAGES];
    t_slot              r_m_slot [MOD_STAGES];

    // Band walk stage
    logic               r_w_vld;
    t_khz               r_w_khz;
    t_slot              r_w_slot;

    // Output stage
    logic               r_o_vld;
    logic [HZ_W-1:0]    r_o_hz;
    t_slot              r_o_slot;

    // Advance the pipe unless the output holds an untaken result
    assign w_adv           = !r_o_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_cfg_ready     = 1'b1;

    // Key register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_network_key <= '0;
        end else if (i_cfg_valid) begin
            r_network_key <= i_cfg_data;
        end
    end

    // Stage 1: clamp fields, weighted sum, slot = x/12 via reciprocal 171/2048
    logic [SEC_W-1:0]  n_sec;
    logic [MIN_W-1:0]  n_min;
    logic [HOUR_W-1:0] n_hour;
    logic [DAY_W-1:0]  n_day;
    logic [6:0]        n_sec_x;
    logic [14:0]       n_slot_prod;
    logic [PSUM_W-1:0] n_psum;

    always_comb begin
        n_sec  = i_s_axis_tdata[5:0];
        n_min  = i_s_axis_tdata[11:6];
        n_hour = i_s_axis_tdata[16:12];
        n_day  = i_s_axis_tdata[21:17];
        if (n_sec > SEC_MAX) begin
            n_sec = SEC_MAX;
        end
        if (n_min > MIN_MAX) begin
            n_min = MIN_MAX;
        end
        if (n_hour > HOUR_MAX) begin
            n_hour = HOUR_MAX;
        end
        n_sec_x     = (n_min[0] ? 7'd60 : 7'd0) + 7'(n_sec);
        n_slot_prod = 15'(n_sec_x) * 15'd171;
        n_psum      = PSUM_W'(n_sec)  * PSUM_W'(47)
                    + PSUM_W'(n_min)  * PSUM_W'(22)
                    + PSUM_W'(n_hour) * PSUM_W'(57)
                    + PSUM_W'(n_day)  * PSUM_W'(43);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_psum <= n_psum;
            r_s1_slot <= t_slot'(n_slot_prod[14:11]);
        end
    end

    // Stage 2: add the key, look up the slot width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_sum  <= SUM_W'(r_network_key) + SUM_W'(r_s1_psum);
            r_s2_slot <= r_s1_slot;
            r_s2_div  <= slot_width(r_s1_slot);
        end
    end

    // Remainder stages: each consumes the next MOD_BITS bits, msb first
    for (genvar k = 0; k < MOD_STAGES; k++) begin : g_mod
        logic             w_vld_in;
        logic [SUM_W-1:0] w_sum_in;
        t_width           w_rem_in;
        t_width           w_div_in;
        t_slot            w_slot_in;

        if (k == 0) begin : g_first
            assign w_vld_in  = r_s2_vld;
            assign w_sum_in  = r_s2_sum;
            assign w_rem_in  = '0;
            assign w_div_in  = r_s2_div;
            assign w_slot_in = r_s2_slot;
        end else begin : g_next
            assign w_vld_in  = r_m_vld[k-1];
            assign w_sum_in  = r_m_sum[k-1];
            assign w_rem_in  = r_m_rem[k-1];
            assign w_div_in  = r_m_div[k-1];
            assign w_slot_in = r_m_slot[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_m_vld[k] <= 1'b0;
            end else if (w_adv) begin
                r_m_vld[k] <= w_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_m_sum[k]  <= w_sum_in;
                r_m_rem[k]  <= mod_step(w_rem_in,
                                        w_sum_in[SUM_W-1-k*MOD_BITS -: MOD_BITS], w_div_in);
                r_m_div[k]  <= w_div_in;
                r_m_slot[k] <= w_slot_in;
            end
        end
    end

    // Band walk: pick the sub-band from the offset and add its start
    t_band  n_band;
    t_width n_off;
    t_khz   n_khz;

    always_comb begin
        n_off  = r_m_rem[MOD_STAGES-1];
        n_band = slot_band(r_m_slot[MOD_STAGES-1]);
        if (n_off < n_band.t1) begin
            n_khz = n_band.a0 + t_khz'(n_off);
        end else if (n_off < n_band.t2) begin
            n_khz = n_band.a1 + t_khz'(n_off);
        end else begin
            n_khz = n_band.a2 + t_khz'(n_off);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_vld <= 1'b0;
        end else if (w_adv) begin
            r_w_vld <= r_m_vld[MOD_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_w_khz  <= n_khz;
            r_w_slot <= r_m_slot[MOD_STAGES-1];
        end
    end

    // Output stage: kHz times 1000 as 1024 - 16 - 8, slot numbered from one
    logic [HZ_W-1:0] n_hz;

    assign n_hz = (HZ_W'(r_w_khz) << 10) - (HZ_W'(r_w_khz) << 4) - (HZ_W'(r_w_khz) << 3);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_adv) begin
            r_o_vld <= r_w_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_hz   <= n_hz;
            r_o_slot <= r_w_slot + t_slot'(1);
        end
    end

    assign o_m_axis_tvalid = r_o_vld;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - HZ_W - SLOT_W){1'b0}}, r_o_slot, r_o_hz};

    // Checks on the pipe
    `HCF_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_s1_vld)
    `HCF_ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n, r_m_vld[MOD_STAGES-1], r_m_rem[MOD_STAGES-1] < r_m_div[MOD_STAGES-1])
    `HCF_ASSERT_IMPL(a_khz_in_band, i_clk, i_rst_n, r_w_vld, (r_w_khz >= t_khz'(KHZ_MIN)) && (r_w_khz <= t_khz'(KHZ_MAX)))
    `HCF_ASSERT_IMPL(a_slot_range, i_clk, i_rst_n, r_o_vld, (r_o_slot >= SLOT_NUM_MIN) && (r_o_slot <= SLOT_NUM_MAX))

endmodule
